// ===== design/sffc_pkg.sv =====
// Shared codes and constants for the small float format converter.
// Used by sffc_narrow, sffc_widen and small_float_format_convert_core.
`timescale 1ns / 1ps

package sffc_pkg;

   // conversion direction codes
   localparam logic KIND_NARROW = 1'b0;
   localparam logic KIND_WIDEN  = 1'b1;

   // format select codes
   localparam logic [1:0] FMT_PASS = 2'd0;
   localparam logic [1:0] FMT_HALF = 2'd1;
   localparam logic [1:0] FMT_U11  = 2'd2;
   localparam logic [1:0] FMT_U10  = 2'd3;

   // float32 field constants
   localparam logic [7:0] F32_EXP_ALL = 8'hFF;
   // float32 exponent of the smallest small-format normal (127 + 1 - 15)
   localparam logic [7:0] MIN_NORMAL_EXP = 8'd113;
   // rebias from small to float32 exponent (127 - 15)
   localparam logic [7:0] REBIAS = 8'd112;
   // float32 exponent of the largest small-format normal (15 + 127)
   localparam logic [7:0] MAX_NORMAL_EXP = 8'd142;

   typedef struct packed {
      logic        has_sign;   // sign bit present (half only)
      logic [4:0]  diff;       // 23 minus mantissa width
      logic [9:0]  frac_mask;  // mantissa mask of the small format
      logic [22:0] max_low;    // mantissa of the largest unclamped value, float32 position
   } fmt_desc_type;

   function automatic fmt_desc_type fmt_desc(input logic [1:0] sel);
      fmt_desc_type d;
      unique case (sel)
         FMT_U11: begin
            d.has_sign  = 1'b0;
            d.diff      = 5'd17;
            d.frac_mask = 10'h03F;
            d.max_low   = 23'h07E000;
         end
         FMT_U10: begin
            d.has_sign  = 1'b0;
            d.diff      = 5'd18;
            d.frac_mask = 10'h01F;
            d.max_low   = 23'h07C000;
         end
         // half; passthrough never uses the descriptor
         FMT_HALF, FMT_PASS: begin
            d.has_sign  = 1'b1;
            d.diff      = 5'd13;
            d.frac_mask = 10'h3FF;
            d.max_low   = 23'h7FE000;
         end
      endcase
      return d;
   endfunction

endpackage

// ===== design/sffc_narrow.sv =====
// Narrowing path: float32 pattern to half, unsigned 11-bit or 10-bit float.
// Depends on sffc_pkg for format descriptors and exponent constants.
`timescale 1ns / 1ps

module sffc_narrow (
   input  logic [1:0]  format_select,
   input  logic [31:0] value_in,
   output logic [15:0] value_out
);

   sffc_pkg::fmt_desc_type d;
   logic [7:0]  exp_f;
   logic [22:0] mant_f;
   logic [30:0] absb;
   logic [30:0] max_normal;
   logic [30:0] min_normal;
   logic [15:0] sign;
   logic [15:0] frac_mask16;
   logic [15:0] exp_mask16;
   logic [15:0] max_pattern;
   logic [7:0]  sh;
   logic [23:0] denorm_m;
   logic [23:0] denorm_sh;
   logic [30:0] norm_v;
   logic [30:0] norm_sh;

   always_comb begin
      d           = sffc_pkg::fmt_desc(format_select);
      exp_f       = value_in[30:23];
      mant_f      = value_in[22:0];
      absb        = value_in[30:0];
      max_normal  = {sffc_pkg::MAX_NORMAL_EXP, d.max_low};
      min_normal  = {sffc_pkg::MIN_NORMAL_EXP, 23'd0};
      sign        = d.has_sign ? {value_in[31], 15'd0} : 16'd0;
      frac_mask16 = {6'd0, d.frac_mask};
      // exponent field sits just above the mantissa: shift an all-ones 5-bit field
      exp_mask16  = ({11'd0, 5'h1F} << (5'd23 - d.diff));
      // exponent 30 with all mantissa bits set: exp mask minus one lowest exp step
      max_pattern = (exp_mask16 & ~(frac_mask16 + 16'd1)) | frac_mask16;
      sh          = sffc_pkg::MIN_NORMAL_EXP - exp_f;
      denorm_m    = {1'b1, mant_f};
      denorm_sh   = (denorm_m >> sh) >> d.diff;
      norm_v      = absb - {sffc_pkg::REBIAS, 23'd0};
      norm_sh     = norm_v >> d.diff;

      priority if (exp_f == sffc_pkg::F32_EXP_ALL && mant_f != 23'd0) begin
         value_out = exp_mask16 | frac_mask16;
      end else if (!d.has_sign && value_in[31]) begin
         value_out = 16'd0;
      end else if (exp_f == sffc_pkg::F32_EXP_ALL) begin
         value_out = sign | exp_mask16;
      end else if (absb > max_normal) begin
         value_out = sign | max_pattern;
      end else if (absb < min_normal) begin
         // float32 zeros and denormals shift out entirely
         value_out = sign | denorm_sh[15:0];
      end else begin
         value_out = sign | norm_sh[15:0];
      end
   end

endmodule

// ===== design/sffc_widen.sv =====
// Widening path: half, unsigned 11-bit or 10-bit float back to float32.
// Depends on sffc_pkg for format descriptors and exponent constants.
`timescale 1ns / 1ps

module sffc_widen (
   input  logic [1:0]  format_select,
   input  logic [15:0] value_in,
   output logic [31:0] value_out
);

   sffc_pkg::fmt_desc_type d;
   logic [4:0]  fb;
   logic [15:0] shifted;
   logic [4:0]  expf;
   logic [9:0]  frac;
   logic [22:0] mant;
   logic        sign;
   logic [3:0]  lz;
   logic [22:0] norm_mant;
   logic [7:0]  norm_exp;

   always_comb begin
      d       = sffc_pkg::fmt_desc(format_select);
      fb      = 5'd23 - d.diff;
      shifted = value_in >> fb;
      expf    = shifted[4:0];
      frac    = value_in[9:0] & d.frac_mask;
      // mantissa top-aligned in the float32 field
      mant    = {13'd0, frac} << d.diff;
      sign    = d.has_sign & value_in[15];

      // leading zeros of the top-aligned mantissa; highest set bit wins
      lz = 4'd0;
      for (int i = 13; i < 23; i++) begin
         if (mant[i]) begin
            lz = 4'(22 - i);
         end
      end
      norm_mant = mant << (lz + 4'd1);
      norm_exp  = sffc_pkg::REBIAS - {4'd0, lz};

      priority if (expf == 5'd0 && frac == 10'd0) begin
         value_out = {sign, 31'd0};
      end else if (expf == 5'd0) begin
         value_out = {sign, norm_exp, norm_mant};
      end else if (expf == 5'h1F) begin
         value_out = {sign, sffc_pkg::F32_EXP_ALL, mant};
      end else begin
         value_out = {sign, {3'd0, expf} + sffc_pkg::REBIAS, mant};
      end
   end

endmodule

// ===== design/small_float_format_convert_core.sv =====
// Top level of the small float format converter: input register, the
// narrowing and widening paths (sffc_narrow, sffc_widen), result register.
// Depends on sffc_pkg.
`timescale 1ns / 1ps

// A beat is taken at every clock edge where start is high; busy is always low,
// so one conversion enters per cycle. Each result appears on rsp_value_out with
// rsp_strobe high for exactly one cycle, after its start beat has passed through
// the input register and then the result register; the receiver cannot stall,
// and results come out in the order the beats went in.
module small_float_format_convert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [1:0]  req_format_select,
   input  logic [31:0] req_value_in,
   output logic        rsp_strobe,
   output logic [31:0] rsp_value_out
);

   logic        in_valid_ff;
   logic        in_kind_ff;
   logic [1:0]  in_sel_ff;
   logic [31:0] in_value_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [31:0] rsp_value_in;
   logic [15:0] narrow_out;
   logic [31:0] widen_out;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         in_kind_ff  <= req_kind;
         in_sel_ff   <= req_format_select;
         in_value_ff <= req_value_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   sffc_narrow u_narrow (
      .format_select (in_sel_ff),
      .value_in      (in_value_ff),
      .value_out     (narrow_out)
   );

   sffc_widen u_widen (
      .format_select (in_sel_ff),
      .value_in      (in_value_ff[15:0]),
      .value_out     (widen_out)
   );

   always_comb begin
      priority if (in_sel_ff == sffc_pkg::FMT_PASS) begin
         rsp_value_in = in_value_ff;
      end else if (in_kind_ff == sffc_pkg::KIND_NARROW) begin
         rsp_value_in = {16'd0, narrow_out};
      end else begin
         rsp_value_in = widen_out;
      end
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

// ===== bench/tb_small_float_format_convert_core.sv =====
// Self-checking bench for small_float_format_convert_core: narrowing, widening and
// passthrough of float bit patterns, checked against an in-bench conversion model.
// Depends on sffc_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_small_float_format_convert_core;

   localparam int HANG_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = sffc_pkg::KIND_NARROW;
   logic [1:0]  req_format_select = sffc_pkg::FMT_PASS;
   logic [31:0] req_value_in = 32'h0;
   logic        rsp_strobe;
   logic [31:0] rsp_value_out;

   logic [31:0] pending_outputs[$];
   int          mismatch_count = 0;
   int          stuck_cycles = 0;
   int          burst_left = 0;

   small_float_format_convert_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_format_select(req_format_select),
      .req_value_in(req_value_in),
      .rsp_strobe(rsp_strobe),
      .rsp_value_out(rsp_value_out)
   );

   always #5 clock = ~clock;

   // mantissa width of each small format
   function automatic int frac_width(input logic [1:0] sel);
      case (sel)
         sffc_pkg::FMT_U11: return 6;
         sffc_pkg::FMT_U10: return 5;
         default: return 10;
      endcase
   endfunction

   // mantissa pattern of the largest unclamped value, float32 position
   function automatic bit [31:0] max_low_f32(input logic [1:0] sel);
      case (sel)
         sffc_pkg::FMT_U11: return 32'h0007_E000;
         sffc_pkg::FMT_U10: return 32'h0007_C000;
         default: return 32'h007F_E000;
      endcase
   endfunction

   function automatic bit [31:0] narrow_to_small(input bit [31:0] f, input logic [1:0] sel);
      int        fw;
      int        shift;
      bit        signed_fmt;
      bit [31:0] mag, frac_mask, exp_field, sign, top_low, max_normal, min_normal, m;
      fw         = frac_width(sel);
      signed_fmt = (sel == sffc_pkg::FMT_HALF);
      mag        = f & 32'h7FFF_FFFF;
      frac_mask  = (32'h1 << fw) - 1;
      exp_field  = 32'h1F << fw;
      sign       = (signed_fmt && f[31]) ? 32'h8000 : 32'h0;
      top_low    = max_low_f32(sel);
      max_normal = (32'(sffc_pkg::MAX_NORMAL_EXP) << 23) | top_low;
      min_normal = 32'(sffc_pkg::MIN_NORMAL_EXP) << 23;
      if (f[30:23] == 8'hFF && f[22:0] != 0) return exp_field | frac_mask;
      if (!signed_fmt && f[31]) return 32'h0;
      if (f[30:23] == 8'hFF) return sign | exp_field;
      if (mag > max_normal) return sign | (32'd30 << fw) | frac_mask;
      if (mag < min_normal) begin
         m     = {9'b1, mag[22:0]};
         shift = int'(sffc_pkg::MIN_NORMAL_EXP) - int'(mag[30:23]);
         m     = (shift < 24) ? (m >> shift) : 32'h0;
         return sign | (m >> (23 - fw));
      end
      return sign | ((mag - (32'(sffc_pkg::REBIAS) << 23)) >> (23 - fw));
   endfunction

   function automatic bit [31:0] widen_to_f32(input bit [31:0] v, input logic [1:0] sel);
      int        fw;
      bit [31:0] frac_mask, expf, frac, sign, e;
      fw        = frac_width(sel);
      frac_mask = (32'h1 << fw) - 1;
      expf      = (v >> fw) & 32'h1F;
      frac      = v & frac_mask;
      sign      = (sel == sffc_pkg::FMT_HALF && v[15]) ? 32'h8000_0000 : 32'h0;
      if (expf == 0) begin
         if (frac == 0) return sign;
         e = 32'(sffc_pkg::MIN_NORMAL_EXP);
         // normalize up to the hidden bit
         for (int i = 0; i < fw && (frac & (frac_mask + 1)) == 0; i++) begin
            e    = e - 1;
            frac = frac << 1;
         end
         return sign | (e << 23) | ((frac & frac_mask) << (23 - fw));
      end
      if (expf == 32'h1F) return sign | 32'h7F80_0000 | (frac << (23 - fw));
      return sign | ((expf + 32'(sffc_pkg::REBIAS)) << 23) | (frac << (23 - fw));
   endfunction

   function automatic bit [31:0] convert_value(input logic k, input logic [1:0] sel,
                                               input bit [31:0] v);
      if (sel == sffc_pkg::FMT_PASS) return v;
      if (k == sffc_pkg::KIND_NARROW) return narrow_to_small(v, sel);
      return widen_to_f32(v, sel);
   endfunction

   // record accepted beats, check results in order
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_value_out);
            mismatch_count++;
         end else begin
            if (rsp_value_out !== pending_outputs[0]) begin
               $display("%0t: value_out expected %h actual %h", $time, pending_outputs[0],
                        rsp_value_out);
               mismatch_count++;
            end
            void'(pending_outputs.pop_front());
         end
      end
      if (!reset && start && !busy)
         pending_outputs.push_back(convert_value(req_kind, req_format_select, req_value_in));
   end

   // watchdog on cycles without any accepted beat or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == HANG_LIMIT) begin
            $display("small_float_format_convert_core: mismatch");
            $finish;
         end
      end
   end

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      req_kind <= 1'($urandom_range(0, 1));
      req_format_select <= 2'($urandom_range(0, 3));
      req_value_in <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_conversion(input logic k, input logic [1:0] sel, input bit [31:0] v);
      if (burst_left == 0) begin
         // occasional zero gap gives long back-to-back stretches
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start <= 1'b1;
      req_kind <= k;
      req_format_select <= sel;
      req_value_in <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_results_drained();
      idle_gap(1);
      while (pending_outputs.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic test_passthrough();
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_PASS, 32'hFFFF_FFFF);
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_PASS, 32'h7FC0_1234);
   endtask

   task automatic test_narrow_special();
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'h7FC0_0001);   // NaN
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U11, 32'hFFFF_FFFF);    // negative NaN
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U11, 32'hBF80_0000);    // negative
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U10, 32'h8000_0000);    // -0
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'h7F80_0000);   // +inf
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'hFF80_0000);   // -inf
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U10, 32'h7F80_0000);
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'hFF7F_FFFF);   // clamps
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'h477F_E000);   // largest
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'hC77F_E001);   // above it
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U11, 32'h477E_0000);
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U11, 32'h4707_E000);
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U10, 32'h4707_C001);
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'h3880_0000);   // min normal
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'hB380_0000);   // min denorm
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U10, 32'h387F_FFFF);    // max denorm
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_HALF, 32'h8000_0001);   // f32 denorm
      send_conversion(sffc_pkg::KIND_NARROW, sffc_pkg::FMT_U11, 32'h0000_0000);
   endtask

   task automatic test_widen_special();
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_HALF, 32'h0000_8000);    // -0
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_HALF, 32'h0000_0001);    // min denorm
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_U11, 32'h0000_003F);     // max denorm
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_U10, 32'h0000_03E0);     // inf
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_U11, 32'h0000_07C1);     // NaN payload
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_HALF, 32'hFFFF_7BFF);    // high bits
      send_conversion(sffc_pkg::KIND_WIDEN, sffc_pkg::FMT_U10, 32'hFFFF_FFFF);
   endtask

   function automatic bit [31:0] random_f32();
      bit [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1: ;
         8: v[30:23] = 8'hFF;
         9: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 113))
                                                    : 8'($urandom_range(141, 143));
         default: v[30:23] = 8'($urandom_range(100, 145));
      endcase
      if ($urandom_range(0, 7) == 0) v[22:0] = ($urandom_range(0, 1) != 0) ? 23'h0 : 23'h7FFFFF;
      return v;
   endfunction

   function automatic bit [31:0] random_small();
      bit [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) != 0) v[31:16] = 16'h0;
      case ($urandom_range(0, 5))
         0: v[14:0] = v[14:0] & 15'h03FF;   // exponent zero in half
         1: v[14:0] = v[14:0] | 15'h7FE0;   // high exponent codes
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_random();
      logic       k;
      logic [1:0] sel;
      for (int n = 0; n < 1100; n++) begin
         k   = 1'($urandom_range(0, 1));
         sel = ($urandom_range(0, 7) == 0) ? sffc_pkg::FMT_PASS : 2'($urandom_range(1, 3));
         send_conversion(k, sel, (k == sffc_pkg::KIND_NARROW) ? random_f32() : random_small());
         if (n % 350 == 349) wait_results_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_narrow_special();
      test_widen_special();
      wait_results_drained();
      test_random();
      wait_results_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && pending_outputs.size() == 0)
         $display("small_float_format_convert_core: match");
      else
         $display("small_float_format_convert_core: mismatch");
      $finish;
   end

endmodule
